FILE: rtl/fixed_point_alu_aligned_defines.svh
`ifndef FIXED_POINT_ALU_ALIGNED_DEFINES_SVH
`define FIXED_POINT_ALU_ALIGNED_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define FPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpa: assertion failed");

// Next-cycle implication, checked on clk_i, off during reset.
`define FPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpa: assertion failed");

`endif

FILE: rtl/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int unsigned VW        = 64;
  localparam int unsigned FW        = 6;
  localparam int unsigned MUL_LAT   = 4;
  localparam int unsigned DIV_STEPS = 2 * VW;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 1;
  localparam int unsigned MUL_DLY   = DIV_LAT - MUL_LAT;

  localparam logic [FW-1:0] DEFAULT_FRAC = 6'd20;
  localparam logic [FW-1:0] MIN_FRAC     = 6'd1;
  localparam logic [FW-1:0] MAX_FRAC     = 6'd62;

  typedef enum logic [3:0] {
    FN_ADD = 4'd0,
    FN_SUB = 4'd1,
    FN_MUL = 4'd2,
    FN_DIV = 4'd3,
    FN_EQ  = 4'd4,
    FN_NE  = 4'd5,
    FN_LE  = 4'd6,
    FN_GE  = 4'd7,
    FN_LT  = 4'd8,
    FN_GT  = 4'd9,
    FN_REQ = 4'd10
  } func_e;

  // Operands after alignment, plus the requantize result of a.
  typedef struct packed {
    logic [3:0]    func;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [FW-1:0] af;
    logic [VW-1:0] rq_val;
    logic [FW-1:0] rq_frac;
    logic          rq_bad;
  } align_t;

  // Result of everything but mul/div, carried alongside the divider.
  typedef struct packed {
    logic [3:0]    func;
    logic [VW-1:0] val;
    logic [FW-1:0] frac;
    logic          cmp;
    logic          badp;
    logic          dz;
  } side_t;

endpackage

FILE: rtl/fpa_align.sv
`timescale 1ns / 1ps
module fpa_align (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [3:0]                func_i,
  input  logic [fpa_pkg::VW-1:0]    a_value_i,
  input  logic [fpa_pkg::FW-1:0]    a_frac_i,
  input  logic [fpa_pkg::VW-1:0]    b_value_i,
  input  logic [fpa_pkg::FW-1:0]    b_frac_i,
  output logic                      valid_o,
  output fpa_pkg::align_t           data_o
);

  logic                   valid_q;
  fpa_pkg::align_t        data_q, data_d;
  logic [fpa_pkg::FW-1:0] tgt;
  logic                   bad;

  always_comb begin
    data_d      = '0;
    data_d.func = func_i;
    data_d.a    = a_value_i;
    data_d.af   = a_frac_i;
    // align b to a's precision
    if (a_frac_i > b_frac_i) begin
      data_d.b = b_value_i << (a_frac_i - b_frac_i);
    end else begin
      data_d.b = $signed(b_value_i) >>> (b_frac_i - a_frac_i);
    end
    bad = (b_frac_i < fpa_pkg::MIN_FRAC) || (b_frac_i > fpa_pkg::MAX_FRAC);
    tgt = bad ? fpa_pkg::DEFAULT_FRAC : b_frac_i;
    if (tgt > a_frac_i) begin
      data_d.rq_val = a_value_i << (tgt - a_frac_i);
    end else begin
      data_d.rq_val = $signed(a_value_i) >>> (a_frac_i - tgt);
    end
    data_d.rq_frac = tgt;
    data_d.rq_bad  = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/fpa_mul.sv
`timescale 1ns / 1ps
module fpa_mul (
  input  logic                   clk_i,
  input  logic [fpa_pkg::VW-1:0] ma_i,
  input  logic [fpa_pkg::VW-1:0] mb_i,
  input  logic                   neg_i,
  input  logic [fpa_pkg::FW-1:0] shift_i,
  output logic [fpa_pkg::VW-1:0] val_o,
  output logic                   ovf_o
);

  localparam int unsigned HW = fpa_pkg::VW / 2;
  localparam int unsigned PW = 2 * fpa_pkg::VW;

  logic [fpa_pkg::VW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [1:0]             neg_q;
  logic [fpa_pkg::FW-1:0] sh1_q, sh2_q, sh3_q;
  logic [PW-1:0]          prod_q, sprod_q, shifted;
  logic [fpa_pkg::VW-1:0] val_q;
  logic                   ovf_q;

  assign shifted = $signed(sprod_q) >>> sh3_q;

  always_ff @(posedge clk_i) begin
    // partial products
    p00_q <= fpa_pkg::VW'(ma_i[HW-1:0]) * fpa_pkg::VW'(mb_i[HW-1:0]);
    p01_q <= fpa_pkg::VW'(ma_i[HW-1:0]) * fpa_pkg::VW'(mb_i[fpa_pkg::VW-1:HW]);
    p10_q <= fpa_pkg::VW'(ma_i[fpa_pkg::VW-1:HW]) * fpa_pkg::VW'(mb_i[HW-1:0]);
    p11_q <= fpa_pkg::VW'(ma_i[fpa_pkg::VW-1:HW]) * fpa_pkg::VW'(mb_i[fpa_pkg::VW-1:HW]);
    neg_q[0] <= neg_i;
    sh1_q    <= shift_i;
    // sum
    prod_q <= PW'(p00_q) + (PW'(p01_q) << HW) + (PW'(p10_q) << HW)
            + (PW'(p11_q) << fpa_pkg::VW);
    neg_q[1] <= neg_q[0];
    sh2_q    <= sh1_q;
    // apply sign
    sprod_q <= neg_q[1] ? (PW'(0) - prod_q) : prod_q;
    sh3_q    <= sh2_q;
    // scale and check fit
    val_q <= shifted[fpa_pkg::VW-1:0];
    ovf_q <= shifted[PW-1:fpa_pkg::VW] != {fpa_pkg::VW{shifted[fpa_pkg::VW-1]}};
  end

  assign val_o = val_q;
  assign ovf_o = ovf_q;

endmodule

FILE: rtl/fpa_div.sv
`timescale 1ns / 1ps
module fpa_div (
  input  logic                          clk_i,
  input  logic [2*fpa_pkg::VW-1:0]      dvd_i,
  input  logic [fpa_pkg::VW-1:0]        dvs_i,
  input  logic                          neg_i,
  output logic [fpa_pkg::VW-1:0]        val_o,
  output logic                          ovf_o
);

  localparam int unsigned VW = fpa_pkg::VW;
  localparam int unsigned DW = 2 * VW;
  localparam int unsigned NS = fpa_pkg::DIV_STEPS;

  logic [VW-1:0] rem_q [NS];
  logic [DW-1:0] dq_q  [NS];
  logic [VW-1:0] d_q   [NS];
  logic          neg_q [NS];
  logic [VW-1:0] val_q;
  logic          ovf_q;

  // one restoring step per stage; dq holds dividend bits on top, quotient bits below
  for (genvar i = 0; i < NS; i++) begin : g_step
    logic [VW-1:0] rem_in, d_in;
    logic [DW-1:0] dq_in;
    logic          neg_in;
    logic [VW:0]   trial, diff;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dvd_i;
      assign d_in   = dvs_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign dq_in  = dq_q[i-1];
      assign d_in   = d_q[i-1];
      assign neg_in = neg_q[i-1];
    end
    assign trial = {rem_in, dq_in[DW-1]};
    assign diff  = trial - {1'b0, d_in};
    always_ff @(posedge clk_i) begin
      if (!diff[VW]) begin
        rem_q[i] <= diff[VW-1:0];
        dq_q[i]  <= {dq_in[DW-2:0], 1'b1};
      end else begin
        rem_q[i] <= trial[VW-1:0];
        dq_q[i]  <= {dq_in[DW-2:0], 1'b0};
      end
      d_q[i]   <= d_in;
      neg_q[i] <= neg_in;
    end
  end

  logic [VW-1:0] ql, qh, limit;
  assign ql    = dq_q[NS-1][VW-1:0];
  assign qh    = dq_q[NS-1][DW-1:VW];
  assign limit = neg_q[NS-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};

  always_ff @(posedge clk_i) begin
    ovf_q <= (qh != '0) || (ql > limit);
    val_q <= neg_q[NS-1] ? (VW'(0) - ql) : ql;
  end

  assign val_o = val_q;
  assign ovf_o = ovf_q;

endmodule

FILE: rtl/fixed_point_alu_aligned.sv
`timescale 1ns / 1ps
// A word accepted at a clock edge shows on the result ports with done_o after
// passing an align stage, an operand stage, the 128-step divider pipeline
// plus its sign stage, and the output register.
// Throughput: one word per cycle, every operation; busy stays low.
// Reset clears all valid bits, so no done_o strobe fires until words arrive.
module fixed_point_alu_aligned (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [3:0]             func_i,
  input  logic [fpa_pkg::VW-1:0] a_value_i,
  input  logic [fpa_pkg::FW-1:0] a_frac_i,
  input  logic [fpa_pkg::VW-1:0] b_value_i,
  input  logic [fpa_pkg::FW-1:0] b_frac_i,
  output logic                   done_o,
  output logic [fpa_pkg::VW-1:0] result_value_o,
  output logic [fpa_pkg::FW-1:0] result_frac_o,
  output logic                   compare_true_o,
  output logic                   overflow_o,
  output logic                   divide_by_zero_o,
  output logic                   bad_precision_o
);

`include "fixed_point_alu_aligned_defines.svh"

  localparam int unsigned VW = fpa_pkg::VW;

  // Every stage advances each cycle; the receiver cannot stall us.
  assign busy = 1'b0;

  // Stage 1: align b, requantize a
  logic            s1_valid;
  fpa_pkg::align_t s1;

  fpa_align u_align (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .func_i    (func_i),
    .a_value_i (a_value_i),
    .a_frac_i  (a_frac_i),
    .b_value_i (b_value_i),
    .b_frac_i  (b_frac_i),
    .valid_o   (s1_valid),
    .data_o    (s1)
  );

  // Stage 2: simple ops finish here; mul/div operands get their magnitudes.
  fpa_pkg::side_t side_d;
  logic [VW-1:0]  ma_d, mb_d;
  logic [2*VW-1:0] dvd_d;

  always_comb begin
    side_d      = '0;
    side_d.func = s1.func;
    case (fpa_pkg::func_e'(s1.func))
      fpa_pkg::FN_ADD: begin
        side_d.val  = s1.a + s1.b;
        side_d.frac = s1.af;
      end
      fpa_pkg::FN_SUB: begin
        side_d.val  = s1.a - s1.b;
        side_d.frac = s1.af;
      end
      fpa_pkg::FN_MUL: side_d.frac = s1.af;
      fpa_pkg::FN_DIV: begin
        side_d.frac = s1.af;
        side_d.dz   = (s1.b == '0);
      end
      fpa_pkg::FN_EQ: side_d.cmp = (s1.a == s1.b);
      fpa_pkg::FN_NE: side_d.cmp = (s1.a != s1.b);
      fpa_pkg::FN_LE: side_d.cmp = ($signed(s1.a) <= $signed(s1.b));
      fpa_pkg::FN_GE: side_d.cmp = ($signed(s1.a) >= $signed(s1.b));
      fpa_pkg::FN_LT: side_d.cmp = ($signed(s1.a) < $signed(s1.b));
      fpa_pkg::FN_GT: side_d.cmp = ($signed(s1.a) > $signed(s1.b));
      fpa_pkg::FN_REQ: begin
        side_d.val  = s1.rq_val;
        side_d.frac = s1.rq_frac;
        side_d.badp = s1.rq_bad;
      end
      default: side_d = '0; // unused codes give an all-zero word
    endcase
    ma_d  = s1.a[VW-1] ? (VW'(0) - s1.a) : s1.a;
    mb_d  = s1.b[VW-1] ? (VW'(0) - s1.b) : s1.b;
    // dividend is |a| scaled up by a's fraction count, exact in 128 bits
    dvd_d = {{VW{1'b0}}, ma_d} << s1.af;
  end

  logic                   s2_valid_q;
  fpa_pkg::side_t         s2_side_q;
  logic [VW-1:0]          s2_ma_q, s2_mb_q;
  logic [2*VW-1:0]        s2_dvd_q;
  logic                   s2_neg_q;
  logic [fpa_pkg::FW-1:0] s2_af_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_side_q <= side_d;
    s2_ma_q   <= ma_d;
    s2_mb_q   <= mb_d;
    s2_dvd_q  <= dvd_d;
    s2_neg_q  <= s1.a[VW-1] ^ s1.b[VW-1];
    s2_af_q   <= s1.af;
  end

  // Multiplier: short pipeline, delayed below to meet the divider.
  logic [VW-1:0] mul_val;
  logic          mul_ovf;

  fpa_mul u_mul (
    .clk_i   (clk_i),
    .ma_i    (s2_ma_q),
    .mb_i    (s2_mb_q),
    .neg_i   (s2_neg_q),
    .shift_i (s2_af_q),
    .val_o   (mul_val),
    .ovf_o   (mul_ovf)
  );

  // Divider: one quotient bit per stage.
  logic [VW-1:0] div_val;
  logic          div_ovf;

  fpa_div u_div (
    .clk_i (clk_i),
    .dvd_i (s2_dvd_q),
    .dvs_i (s2_mb_q),
    .neg_i (s2_neg_q),
    .val_o (div_val),
    .ovf_o (div_ovf)
  );

  // Side line: valid and simple result travel beside the divider.
  logic [fpa_pkg::DIV_LAT-1:0] side_vld_q;
  fpa_pkg::side_t              side_q [fpa_pkg::DIV_LAT];
  logic [VW-1:0]               mdl_val_q [fpa_pkg::MUL_DLY];
  logic [fpa_pkg::MUL_DLY-1:0] mdl_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_vld_q <= '0;
    end else begin
      side_vld_q <= {side_vld_q[fpa_pkg::DIV_LAT-2:0], s2_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= s2_side_q;
    for (int k = 1; k < fpa_pkg::DIV_LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
    mdl_val_q[0] <= mul_val;
    for (int k = 1; k < fpa_pkg::MUL_DLY; k++) begin
      mdl_val_q[k] <= mdl_val_q[k-1];
    end
    mdl_ovf_q <= {mdl_ovf_q[fpa_pkg::MUL_DLY-2:0], mul_ovf};
  end

  // Output register: pick the unit that owns this word.
  fpa_pkg::side_t fin;
  logic [VW-1:0]  out_val_d;
  logic           out_ovf_d;

  assign fin = side_q[fpa_pkg::DIV_LAT-1];

  always_comb begin
    out_val_d = fin.val;
    out_ovf_d = 1'b0;
    case (fpa_pkg::func_e'(fin.func))
      fpa_pkg::FN_MUL: begin
        out_val_d = mdl_val_q[fpa_pkg::MUL_DLY-1];
        out_ovf_d = mdl_ovf_q[fpa_pkg::MUL_DLY-1];
      end
      fpa_pkg::FN_DIV: begin
        // drop the quotient on a zero divisor
        out_val_d = fin.dz ? '0 : div_val;
        out_ovf_d = fin.dz ? 1'b0 : div_ovf;
      end
      default: begin
        out_val_d = fin.val;
        out_ovf_d = 1'b0;
      end
    endcase
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_vld_q[fpa_pkg::DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    result_value_o   <= out_val_d;
    result_frac_o    <= fin.frac;
    compare_true_o   <= fin.cmp;
    overflow_o       <= out_ovf_d;
    divide_by_zero_o <= fin.dz;
    bad_precision_o  <= fin.badp;
  end

  assign done_o = done_q;

  `FPA_ASSERT_IMP(a_dz_clean, done_o && divide_by_zero_o, result_value_o == '0 && !overflow_o)
  `FPA_ASSERT_IMP(a_badp_frac, done_o && bad_precision_o, result_frac_o == fpa_pkg::DEFAULT_FRAC)
  `FPA_ASSERT_IMP(a_cmp_zero, done_o && compare_true_o, result_value_o == '0 && result_frac_o == '0)
  `FPA_ASSERT_NXT(a_side_done, side_vld_q[fpa_pkg::DIV_LAT-1], done_o)

endmodule

FILE: verif/fpa_checker.sv
`timescale 1ns / 1ps
module fpa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [3:0]  func_i,
  input  logic [63:0] a_value_i,
  input  logic [5:0]  a_frac_i,
  input  logic [63:0] b_value_i,
  input  logic [5:0]  b_frac_i,
  input  logic        done_i,
  input  logic [63:0] result_value_i,
  input  logic [5:0]  result_frac_i,
  input  logic        compare_true_i,
  input  logic        overflow_i,
  input  logic        divide_by_zero_i,
  input  logic        bad_precision_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [63:0] val;
    logic [5:0]  frac;
    logic        cmp;
    logic        ovf;
    logic        dz;
    logic        badp;
  } alu_result_t;

  alu_result_t expected_q[$];

  function automatic alu_result_t alu_predict(logic [3:0] fn, logic signed [63:0] a,
                                              logic [5:0] af, logic signed [63:0] b,
                                              logic [5:0] bf);
    alu_result_t r;
    logic signed [63:0]  bal;
    logic signed [127:0] aw, bw, p, q;
    logic [5:0]          t;
    r = '0;
    if (af > bf) bal = b << (af - bf);
    else bal = b >>> (bf - af);
    aw = a;
    bw = bal;
    case (fn)
      fpa_pkg::FN_ADD: begin r.val = a + bal; r.frac = af; end
      fpa_pkg::FN_SUB: begin r.val = a - bal; r.frac = af; end
      fpa_pkg::FN_MUL: begin
        p = (aw * bw) >>> af;
        r.val = p[63:0];
        r.ovf = (p != {{64{p[63]}}, p[63:0]});
        r.frac = af;
      end
      fpa_pkg::FN_DIV: begin
        r.frac = af;
        if (bal == 0) begin
          r.dz = 1'b1;
        end else begin
          q = (aw <<< af) / bw;
          r.val = q[63:0];
          r.ovf = (q != {{64{q[63]}}, q[63:0]});
        end
      end
      fpa_pkg::FN_EQ: r.cmp = (a == bal);
      fpa_pkg::FN_NE: r.cmp = (a != bal);
      fpa_pkg::FN_LE: r.cmp = (a <= bal);
      fpa_pkg::FN_GE: r.cmp = (a >= bal);
      fpa_pkg::FN_LT: r.cmp = (a < bal);
      fpa_pkg::FN_GT: r.cmp = (a > bal);
      fpa_pkg::FN_REQ: begin
        t = bf;
        if (t < fpa_pkg::MIN_FRAC || t > fpa_pkg::MAX_FRAC) begin
          r.badp = 1'b1;
          t = fpa_pkg::DEFAULT_FRAC;
        end
        if (t > af) r.val = a << (t - af);
        else r.val = a >>> (af - t);
        r.frac = t;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    alu_result_t got, want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      // Queue a prediction for every word the block takes.
      if (start_i && !busy_i)
        expected_q.push_back(alu_predict(func_i, a_value_i, a_frac_i, b_value_i, b_frac_i));
      if (done_i) begin
        got = '{result_value_i, result_frac_i, compare_true_i, overflow_i,
                divide_by_zero_i, bad_precision_i};
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result word %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %p got %p", want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  func_i = '0;
  logic [63:0] a_value_i = '0;
  logic [5:0]  a_frac_i = 6'd1;
  logic [63:0] b_value_i = '0;
  logic [5:0]  b_frac_i = 6'd1;
  logic        done_o;
  logic [63:0] result_value_o;
  logic [5:0]  result_frac_o;
  logic        compare_true_o, overflow_o, divide_by_zero_o, bad_precision_o;
  int          fail_count, pending;
  int          sent;

  localparam logic [63:0] MAX_V = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;

  fixed_point_alu_aligned dut (.*);

  fpa_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .func_i, .a_value_i, .a_frac_i,
    .b_value_i, .b_frac_i, .done_i(done_o), .result_value_i(result_value_o),
    .result_frac_i(result_frac_o), .compare_true_i(compare_true_o),
    .overflow_i(overflow_o), .divide_by_zero_i(divide_by_zero_o),
    .bad_precision_i(bad_precision_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Present one word and hold it until the block takes it. busy only moves at
  // the rising edge, so reading it at the falling edge tells what the next
  // edge will see.
  task automatic send_word(logic [3:0] fn, logic [63:0] a, logic [5:0] af,
                           logic [63:0] b, logic [5:0] bf);
    logic taken;
    start <= 1'b1;
    func_i <= fn;
    a_value_i <= a;
    a_frac_i <= af;
    b_value_i <= b;
    b_frac_i <= bf;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    sent++;
  endtask

  // Drop start for a number of cycles between bursts.
  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Mix extremes, small magnitudes and full-width noise so that both the
  // overflow paths and the in-range paths see plenty of traffic.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = MAX_V;
      1: v = MIN_V;
      2: v = 64'd0;
      3: v = {$urandom, $urandom};
      4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(20, 62);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [5:0] pick_frac();
    if ($urandom_range(0, 15) == 0) return 6'($urandom);
    return 6'($urandom_range(1, 62));
  endfunction

  initial begin
    int burst;
    sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every operation, the special cases.
    send_word(fpa_pkg::FN_ADD, MAX_V, 6'd1, 64'd1, 6'd1);          // wrap on add
    send_word(fpa_pkg::FN_SUB, MIN_V, 6'd62, 64'd1, 6'd62);        // wrap on subtract
    send_word(fpa_pkg::FN_ADD, 64'd1, 6'd62, MAX_V, 6'd0);         // alignment left loses bits
    send_word(fpa_pkg::FN_SUB, 64'd3, 6'd0, MIN_V, 6'd63);         // alignment right, sign kept
    send_word(fpa_pkg::FN_MUL, MAX_V, 6'd1, MAX_V, 6'd1);          // multiply overflow
    send_word(fpa_pkg::FN_MUL, MIN_V, 6'd63, MIN_V, 6'd63);
    send_word(fpa_pkg::FN_MUL, 64'hffff_ffff_ffff_fffd, 6'd4, 64'd40, 6'd4);
    send_word(fpa_pkg::FN_DIV, 64'd100, 6'd8, 64'd0, 6'd8);        // divide by zero
    send_word(fpa_pkg::FN_DIV, 64'd5, 6'd1, 64'd1, 6'd63);         // divisor aligns to zero
    send_word(fpa_pkg::FN_DIV, MIN_V, 6'd62, 64'hffff_ffff_ffff_ffff, 6'd62);  // overflow
    send_word(fpa_pkg::FN_DIV, MAX_V, 6'd0, MIN_V, 6'd0);
    send_word(fpa_pkg::FN_DIV, 64'hffff_ffff_ffff_fff9, 6'd3, 64'd2, 6'd3);
    send_word(fpa_pkg::FN_EQ, 64'd16, 6'd4, 64'd1, 6'd0);
    send_word(fpa_pkg::FN_NE, 64'd16, 6'd4, 64'd1, 6'd0);
    send_word(fpa_pkg::FN_LE, MIN_V, 6'd10, MAX_V, 6'd10);
    send_word(fpa_pkg::FN_GE, MIN_V, 6'd10, MAX_V, 6'd10);
    send_word(fpa_pkg::FN_LT, MAX_V, 6'd10, MAX_V, 6'd10);
    send_word(fpa_pkg::FN_GT, MAX_V, 6'd10, MIN_V, 6'd10);
    send_word(fpa_pkg::FN_REQ, MAX_V, 6'd1, 64'd0, 6'd62);         // precision up, wrapping
    send_word(fpa_pkg::FN_REQ, MIN_V, 6'd62, 64'd0, 6'd1);         // precision down
    send_word(fpa_pkg::FN_REQ, 64'd12345, 6'd10, 64'd0, 6'd0);     // bad target, low
    send_word(fpa_pkg::FN_REQ, 64'd12345, 6'd30, 64'd0, 6'd63);    // bad target, high
    send_word(4'd11, MAX_V, 6'd5, MIN_V, 6'd5);           // unused codes
    send_word(4'd15, MIN_V, 6'd63, MAX_V, 6'd63);

    // Random part in bursts, some stretches without gaps at all.
    while (sent < 1330) begin
      burst = $urandom_range(1, 40);
      repeat (burst)
        send_word(4'($urandom_range(0, 15) < 15 ? $urandom_range(0, 10)
                                                 : $urandom_range(11, 15)),
                  pick_value(), pick_frac(), pick_value(), pick_frac());
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
    end
    start <= 1'b0;

    // Drain the pipeline, then wait on for stray strobes.
    while (pending != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);

    $display("Ran %0d words: all eleven operations, unused codes, extreme operands", sent);
    $display("and fraction counts, with bursty start and back-to-back traffic.");
    if (fail_count == 0) begin
      $display("PASS fixed_point_alu_aligned");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAIL fixed_point_alu_aligned");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("FAIL fixed_point_alu_aligned");
    $finish;
  end

endmodule
